/* rtl/pes_pkg.sv */
package pes_pkg;

   localparam int MAX_SPAN_DEF    = 65536;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CFG_W      = 17;
   localparam int RATIO_W    = 17;
   localparam int IDX_W      = 32;
   localparam int STRENGTH_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register indexes (byte address 4*index)
   localparam logic REG_MAX_SPAN  = 1'b0;
   localparam logic REG_MIN_RATIO = 1'b1;

   localparam logic [CFG_W-1:0] MAX_SPAN_RESET  = 17'd4800;
   localparam logic [CFG_W-1:0] MIN_RATIO_RESET = 17'd0;

   // quotient bits produced by the serial divider
   localparam int DIV_STEPS  = RATIO_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [CFG_W-1:0] max_span;
      logic [CFG_W-1:0] min_ratio;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/pes_channels.sv */
interface pes_req_if #(
   parameter int SAMPLE_BITS = pes_pkg::SAMPLE_BITS_DEF
);
   import pes_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] percussive_sample;
   logic signed [SAMPLE_BITS-1:0] harmonic_sample;
   logic                          onset_here;
   logic [STRENGTH_W-1:0]         onset_strength;
   logic                          last_sample;

   modport source (
      output valid, percussive_sample, harmonic_sample, onset_here, onset_strength,
             last_sample,
      input  ready
   );
   modport sink (
      input  valid, percussive_sample, harmonic_sample, onset_here, onset_strength,
             last_sample,
      output ready
   );
endinterface

interface pes_rsp_if #(
   parameter int SAMPLE_BITS = pes_pkg::SAMPLE_BITS_DEF
);
   import pes_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [IDX_W-1:0]       event_begin;
   logic [IDX_W-1:0]       event_end;
   logic [STRENGTH_W-1:0]  event_strength;
   logic [SAMPLE_BITS-1:0] peak_level;
   logic [RATIO_W-1:0]     perc_share;
   logic                   last_of_run;

   modport source (
      output valid, event_begin, event_end, event_strength, peak_level,
             perc_share, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, event_begin, event_end, event_strength, peak_level,
             perc_share, last_of_run,
      output ready
   );
endinterface

/* rtl/pes_csr.sv */
module pes_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pes_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pes_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pes_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output pes_pkg::cfg_type                 cfg
);
   import pes_pkg::*;

   logic [CFG_W-1:0] max_span_ff, max_span_in;
   logic [CFG_W-1:0] min_ratio_ff, min_ratio_in;
   logic             wr_en;
   logic             sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign sel        = csr_paddr[2];

   always_comb begin
      max_span_in  = max_span_ff;
      min_ratio_in = min_ratio_ff;
      if (wr_en) begin
         case (sel)
            REG_MAX_SPAN:  max_span_in  = csr_pwdata[CFG_W-1:0];
            REG_MIN_RATIO: min_ratio_in = csr_pwdata[CFG_W-1:0];
            default:       max_span_in  = max_span_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_span_ff  <= MAX_SPAN_RESET;
         min_ratio_ff <= MIN_RATIO_RESET;
      end else begin
         max_span_ff  <= max_span_in;
         min_ratio_ff <= min_ratio_in;
      end
   end

   always_comb begin
      case (sel)
         REG_MAX_SPAN:  csr_prdata = CSR_DATA_W'(max_span_ff);
         REG_MIN_RATIO: csr_prdata = CSR_DATA_W'(min_ratio_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.max_span  = max_span_ff;
   assign cfg.min_ratio = min_ratio_ff;

endmodule

/* rtl/pes_divider.sv */
module pes_divider #(
   parameter int ENERGY_W = 47
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ENERGY_W-1:0]           perc_energy,
   input  logic [ENERGY_W-1:0]           harm_energy,
   output logic [pes_pkg::RATIO_W-1:0]   quotient,
   output pes_pkg::div_stat_type         stat
);
   import pes_pkg::*;

   localparam int T_W = ENERGY_W + 1;
   localparam int R_W = ENERGY_W + 2;

   logic [T_W-1:0]        total_ff, total_in;
   logic [R_W-1:0]        rem_ff, rem_in;
   logic [RATIO_W-1:0]    quo_ff, quo_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  zero_ff, zero_in;

   logic [T_W-1:0] sum;
   logic [R_W-1:0] shifted;
   logic           take;

   assign sum     = T_W'(perc_energy) + T_W'(harm_energy);
   // first step compares the numerator itself, later ones the doubled remainder
   assign shifted = (step_ff == '0) ? rem_ff : {rem_ff[R_W-2:0], 1'b0};
   assign take    = shifted >= R_W'(total_ff);

   always_comb begin
      total_in = total_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      zero_in  = zero_ff;
      done_in  = 1'b0;
      if (start) begin
         total_in = sum;
         rem_in   = R_W'(perc_energy);
         quo_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
         zero_in  = (sum == '0);
      end else if (busy_ff) begin
         rem_in  = take ? (shifted - R_W'(total_ff)) : shifted;
         quo_in  = {quo_ff[RATIO_W-2:0], take};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      total_ff <= total_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      zero_ff  <= zero_in;
   end

   assign quotient  = zero_ff ? '0 : quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/percussive_event_segmenter.sv */
// percussive event segmenter
// req_chan carries one audio sample per transaction: percussive and harmonic
// samples, an onset mark with its strength and an end-of-audio mark. rsp_chan
// carries one transaction per closed span that passes the ratio threshold,
// with last_of_run set on the final one caused by a sample (at most two).
// a sample is taken, then req_chan.ready stays low while a small sequencer
// works it through: one squaring multiplier and one saturating adder handle
// the two energies in S_SQP, S_SQH and S_ACC, and each span close runs the
// ratio through a 17-step serial divider. a sample inside a span passes
// S_OPEN, the energy steps, S_CHK and S_EMIT, one outside any span S_OPEN
// and S_EMIT only; a close adds S_DINIT and S_DIV, an onset ending a span
// runs its close before S_OPEN. results leave through an output register so
// the last one may still wait while the next sample is taken.
// a stalled rsp_chan only holds the sequencer at its emit step.
// reset (synchronous, active high) clears the span, the sample counter and
// both registers to their defaults; no clearing pass is needed.
// registers on the csr port: 0x0 max_span_samples, 0x4 min_ratio.
module percussive_event_segmenter #(
   parameter int MAX_SPAN    = pes_pkg::MAX_SPAN_DEF,
   parameter int SAMPLE_BITS = pes_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   pes_req_if.sink                        req_chan,
   pes_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pes_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pes_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int SQ_W   = 2 * SB - 1;
   localparam int LEN_W  = $clog2(MAX_SPAN + 1);
   localparam int E_RAW  = 2 * SB - 2 + LEN_W;
   // energy sums saturate at 2^E_W - 1, all ones in E_W bits; E_W is at most 62
   localparam int E_W    = (E_RAW > 62) ? 62 : E_RAW;
   localparam int CW     = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam logic [CW-1:0] MAX_CAP = CW'(MAX_SPAN);

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_OPEN  = 4'd1;
   localparam logic [3:0] S_SQP   = 4'd2;
   localparam logic [3:0] S_SQH   = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_CHK   = 4'd5;
   localparam logic [3:0] S_DINIT = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   typedef struct packed {
      logic [IDX_W-1:0]      event_begin;
      logic [IDX_W-1:0]      event_end;
      logic [STRENGTH_W-1:0] event_strength;
      logic [SB-1:0]         peak_level;
      logic [RATIO_W-1:0]    perc_share;
   } res_type;

   cfg_type      cfg;
   div_stat_type div_stat;
   logic [RATIO_W-1:0] div_quo;
   logic         div_start;

   pes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer and sample latch
   logic [3:0]            state_ff, state_in;
   logic [IDX_W-1:0]      sample_index_ff, sample_index_in;
   logic [IDX_W-1:0]      cur_idx_ff, cur_idx_in;
   logic                  onset_ff, onset_in;
   logic                  last_ff, last_in;
   logic [STRENGTH_W-1:0] strength_ff, strength_in;
   logic [SB-1:0]         pmag_ff, pmag_in;
   logic [SB-1:0]         hmag_ff, hmag_in;

   // open span
   logic                  span_open_ff, span_open_in;
   logic [IDX_W-1:0]      span_begin_ff, span_begin_in;
   logic [LEN_W-1:0]      span_len_ff, span_len_in;
   logic [STRENGTH_W-1:0] span_strength_ff, span_strength_in;
   logic [SB-1:0]         span_peak_ff, span_peak_in;
   logic [E_W-1:0]        pe_ff, pe_in;
   logic [E_W-1:0]        he_ff, he_in;
   logic [SQ_W-1:0]       prod_ff, prod_in;

   // close bookkeeping and the two-entry result buffer
   logic [IDX_W-1:0]      close_end_ff, close_end_in;
   logic                  close_onset_ff, close_onset_in;
   res_type               res_ff [2];
   res_type               res_new;
   logic                  res_wr;
   logic [1:0]            res_count_ff, res_count_in;
   logic                  emit_sel_ff, emit_sel_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   res_type               rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  out_free;
   logic                  emit_last;
   logic [SB-1:0]         in_pmag, in_hmag;
   logic [SB-1:0]         mul_a;
   logic [2*SB-1:0]       mul_full;
   logic [E_W-1:0]        acc_a;
   logic [E_W:0]          acc_sum;
   logic [E_W-1:0]        acc_sat;
   logic [CW-1:0]         cap_raw, cap_eff;

   pes_divider #(.ENERGY_W(E_W)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .perc_energy (pe_ff),
      .harm_energy (he_ff),
      .quotient    (div_quo),
      .stat        (div_stat)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign div_start      = (state_ff == S_DINIT);

   // magnitudes; the most negative code maps onto 2^(SB-1) unsigned
   assign in_pmag = req_chan.percussive_sample[SB-1] ?
                    SB'(-req_chan.percussive_sample) : SB'(req_chan.percussive_sample);
   assign in_hmag = req_chan.harmonic_sample[SB-1] ?
                    SB'(-req_chan.harmonic_sample) : SB'(req_chan.harmonic_sample);

   // shared squarer and saturating accumulator
   assign mul_a    = (state_ff == S_SQP) ? pmag_ff : hmag_ff;
   assign mul_full = mul_a * mul_a;
   assign acc_a    = (state_ff == S_SQH) ? pe_ff : he_ff;
   assign acc_sum  = (E_W + 1)'(acc_a) + (E_W + 1)'(prod_ff);
   assign acc_sat  = acc_sum[E_W] ? {E_W{1'b1}} : acc_sum[E_W-1:0];

   // span cap: zero means one, anything past the build limit clamps to it
   assign cap_raw = CW'(cfg.max_span);
   assign cap_eff = (cap_raw == '0) ? CW'(1) : ((cap_raw > MAX_CAP) ? MAX_CAP : cap_raw);

   assign res_new.event_begin    = span_begin_ff;
   assign res_new.event_end      = close_end_ff;
   assign res_new.event_strength = span_strength_ff;
   assign res_new.peak_level     = span_peak_ff;
   assign res_new.perc_share     = div_quo;

   assign emit_last = ({1'b0, emit_sel_ff} + 2'd1) == res_count_ff;

   always_comb begin
      state_in         = state_ff;
      sample_index_in  = sample_index_ff;
      cur_idx_in       = cur_idx_ff;
      onset_in         = onset_ff;
      last_in          = last_ff;
      strength_in      = strength_ff;
      pmag_in          = pmag_ff;
      hmag_in          = hmag_ff;
      span_open_in     = span_open_ff;
      span_begin_in    = span_begin_ff;
      span_len_in      = span_len_ff;
      span_strength_in = span_strength_ff;
      span_peak_in     = span_peak_ff;
      pe_in            = pe_ff;
      he_in            = he_ff;
      prod_in          = prod_ff;
      close_end_in     = close_end_ff;
      close_onset_in   = close_onset_ff;
      res_count_in     = res_count_ff;
      emit_sel_in      = emit_sel_ff;
      res_wr           = 1'b0;
      rsp_valid_in     = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_last_in      = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_idx_in      = sample_index_ff;
               sample_index_in = req_chan.last_sample ? '0 : sample_index_ff + 1'b1;
               onset_in        = req_chan.onset_here;
               last_in         = req_chan.last_sample;
               strength_in     = req_chan.onset_strength;
               pmag_in         = in_pmag;
               hmag_in         = in_hmag;
               res_count_in    = '0;
               emit_sel_in     = 1'b0;
               if (req_chan.onset_here && span_open_ff) begin
                  // onset ends the running span on this very sample
                  close_end_in   = sample_index_ff;
                  close_onset_in = 1'b1;
                  state_in       = S_DINIT;
               end else begin
                  state_in = S_OPEN;
               end
            end
         end
         S_OPEN: begin
            if (onset_ff) begin
               span_open_in     = 1'b1;
               span_begin_in    = cur_idx_ff;
               span_len_in      = '0;
               span_strength_in = strength_ff;
               span_peak_in     = '0;
               pe_in            = '0;
               he_in            = '0;
               state_in         = S_SQP;
            end else begin
               // samples outside any span are dropped
               state_in = span_open_ff ? S_SQP : S_EMIT;
            end
         end
         S_SQP: begin
            prod_in  = mul_full[SQ_W-1:0];
            state_in = S_SQH;
         end
         S_SQH: begin
            pe_in    = acc_sat;
            prod_in  = mul_full[SQ_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            he_in       = acc_sat;
            span_len_in = span_len_ff + 1'b1;
            if (pmag_ff > span_peak_ff) begin
               span_peak_in = pmag_ff;
            end
            state_in = S_CHK;
         end
         S_CHK: begin
            if ((CW'(span_len_ff) >= cap_eff) || last_ff) begin
               close_end_in   = cur_idx_ff + 1'b1;
               close_onset_in = 1'b0;
               state_in       = S_DINIT;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DINIT: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               if (div_quo >= cfg.min_ratio) begin
                  res_wr       = 1'b1;
                  res_count_in = res_count_ff + 1'b1;
               end
               span_open_in = 1'b0;
               span_len_in  = '0;
               span_peak_in = '0;
               pe_in        = '0;
               he_in        = '0;
               state_in     = close_onset_ff ? S_OPEN : S_EMIT;
            end
         end
         S_EMIT: begin
            if (res_count_ff == '0) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff[emit_sel_ff];
               rsp_last_in  = emit_last;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  emit_sel_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         sample_index_ff  <= '0;
         span_open_ff     <= 1'b0;
         span_begin_ff    <= '0;
         span_len_ff      <= '0;
         span_strength_ff <= '0;
         span_peak_ff     <= '0;
         pe_ff            <= '0;
         he_ff            <= '0;
         res_count_ff     <= '0;
         emit_sel_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         sample_index_ff  <= sample_index_in;
         span_open_ff     <= span_open_in;
         span_begin_ff    <= span_begin_in;
         span_len_ff      <= span_len_in;
         span_strength_ff <= span_strength_in;
         span_peak_ff     <= span_peak_in;
         pe_ff            <= pe_in;
         he_ff            <= he_in;
         res_count_ff     <= res_count_in;
         emit_sel_ff      <= emit_sel_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cur_idx_ff     <= cur_idx_in;
      onset_ff       <= onset_in;
      last_ff        <= last_in;
      strength_ff    <= strength_in;
      pmag_ff        <= pmag_in;
      hmag_ff        <= hmag_in;
      prod_ff        <= prod_in;
      close_end_ff   <= close_end_in;
      close_onset_ff <= close_onset_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
      if (res_wr) begin
         res_ff[res_count_ff[0]] <= res_new;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.event_begin    = rsp_data_ff.event_begin;
   assign rsp_chan.event_end      = rsp_data_ff.event_end;
   assign rsp_chan.event_strength = rsp_data_ff.event_strength;
   assign rsp_chan.peak_level     = rsp_data_ff.peak_level;
   assign rsp_chan.perc_share     = rsp_data_ff.perc_share;
   assign rsp_chan.last_of_run    = rsp_last_ff;

   // no more than two events from one sample
   a_res_count: assert property (@(posedge clock) disable iff (reset)
      res_count_ff <= 2'd2)
      else $error("result buffer overfilled");

   // a taken sample blocks the input until its work is through
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("input ready straight after a transaction");

   // only events at or above the threshold leave the block
   a_ratio_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.perc_share >= cfg.min_ratio))
      else $error("event below min_ratio emitted");

   // a span never grows past the build limit
   a_span_len: assert property (@(posedge clock) disable iff (reset)
      CW'(span_len_ff) <= MAX_CAP)
      else $error("span longer than MAX_SPAN");

   // the divider is only started from an idle state
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

endmodule
